// ===== rtl/tws_pkg.sv =====
`default_nettype none

package tws_pkg;

    localparam int unsigned TotalBits      = 16;
    localparam int unsigned ByteBits       = 8;
    localparam logic [7:0]  HalfPeriodRst  = 8'd2;
    localparam logic [7:0]  TickSat        = 8'hff;

    // depth of the item queue and of the result queue
    localparam int unsigned QueueDepth     = 2;
    localparam int unsigned QPtrW          = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned QCntW          = $clog2(QueueDepth + 1);

    localparam logic        FuncWrite      = 1'b0;
    localparam logic        FuncRead       = 1'b1;

    typedef struct packed {
        logic       start_req;
        logic       func;
        logic [7:0] address;
        logic [7:0] write_data;
        logic       io_in;
    } tws_item_t;

    typedef struct packed {
        logic       sclk;
        logic       io_out;
        logic       io_drive;
        logic       chip_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } tws_result_t;

    // handshake between front and back
    typedef struct packed {
        logic valid;
        logic start;
    } tws_link_t;

    function automatic logic [QPtrW-1:0] qptr_inc(input logic [QPtrW-1:0] p);
        logic [QPtrW-1:0] r;
        if (p == QPtrW'(QueueDepth - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tws_front.sv =====
`default_nettype none

module tws_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire tws_pkg::tws_item_t in_item,
    output tws_pkg::tws_item_t      item,
    output tws_pkg::tws_link_t      link,
    input  wire logic               take
);
    import tws_pkg::*;

    tws_item_t          q_reg [QueueDepth];
    logic [QPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == QCntW'(QueueDepth));
    assign do_push = push && !full;
    assign do_pop  = take && (cnt_reg != '0);

    assign item       = q_reg[rd_ptr_reg];
    assign link.valid = (cnt_reg != '0);
    // classify: a start request is the only kind of beat that can open a transaction
    assign link.start = q_reg[rd_ptr_reg].start_req;

    always_comb
    begin
        wr_ptr_next = do_push ? qptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? qptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= in_item;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCntW'(QueueDepth))
        else $error("item queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("item queue pointers disagree with count");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !take) |=> full)
        else $error("item queue lost a beat while full");

endmodule

`default_nettype wire

// ===== rtl/tws_back.sv =====
`default_nettype none

module tws_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           half_period,
    input  wire tws_pkg::tws_item_t   item,
    input  wire tws_pkg::tws_link_t   link,
    output logic                      take,
    output tws_pkg::tws_result_t      result,
    output logic                      empty,
    input  wire logic                 pop
);
    import tws_pkg::*;

    logic [15:0]      send_shift_reg, send_shift_next;
    logic [7:0]       recv_shift_reg, recv_shift_next;
    logic [4:0]       bit_index_reg,  bit_index_next;
    logic [7:0]       tick_count_reg, tick_count_next;
    logic             read_mode_reg,  read_mode_next;
    logic             active_reg,     active_next;
    logic             clock_reg,      clock_next;

    tws_result_t      oq_reg [QueueDepth];
    logic [QPtrW-1:0] owr_ptr_reg, orw_dummy;
    logic [QPtrW-1:0] ord_ptr_reg;
    logic [QCntW-1:0] ocnt_reg, ocnt_next;

    logic [7:0]       hp;
    logic [7:0]       tick_inc;
    logic [4:0]       bit_inc;
    logic             done;
    logic             drive;
    logic             level;
    logic             step;
    logic             do_pop;
    tws_result_t      res;

    assign do_pop = pop && (ocnt_reg != '0);
    assign step   = link.valid &&
                    ((ocnt_reg != QCntW'(QueueDepth)) || do_pop);
    assign take   = step;
    assign empty  = (ocnt_reg == '0);
    assign result = oq_reg[ord_ptr_reg];

    assign hp       = (half_period == 8'd0) ? 8'd1 : half_period;
    assign tick_inc = (tick_count_reg < TickSat) ? tick_count_reg + 8'd1 : tick_count_reg;
    assign bit_inc  = bit_index_reg + 5'd1;

    always_comb
    begin
        send_shift_next = send_shift_reg;
        recv_shift_next = recv_shift_reg;
        bit_index_next  = bit_index_reg;
        tick_count_next = tick_count_reg;
        read_mode_next  = read_mode_reg;
        active_next     = active_reg;
        clock_next      = clock_reg;
        done            = 1'b0;

        if (active_reg)
        begin
            tick_count_next = tick_inc;
            if (tick_inc >= hp)
            begin
                tick_count_next = 8'd0;
                if (!clock_reg)
                begin
                    // sample on the low-to-high clock edge during the data byte of a read
                    if (read_mode_reg && (bit_index_reg >= 5'(ByteBits))
                        && (bit_index_reg < 5'(TotalBits)))
                        recv_shift_next = {item.io_in, recv_shift_reg[7:1]};
                    clock_next = 1'b1;
                end
                else
                begin
                    bit_index_next = bit_inc;
                    clock_next     = 1'b0;
                    if (bit_inc >= 5'(TotalBits))
                    begin
                        active_next    = 1'b0;
                        clock_next     = 1'b1;
                        bit_index_next = 5'd0;
                        done           = 1'b1;
                    end
                end
            end
        end
        else if (link.start)
        begin
            active_next     = 1'b1;
            read_mode_next  = item.func;
            send_shift_next = {(item.func == FuncRead) ? 8'h00 : item.write_data,
                               item.address};
            if (item.func == FuncRead)
                recv_shift_next = 8'h00;
            bit_index_next  = 5'd0;
            tick_count_next = 8'd0;
            clock_next      = 1'b0;
        end

        drive = active_next && !(read_mode_next && (bit_index_next >= 5'(ByteBits)));
        level = drive && send_shift_next[bit_index_next[3:0]];

        res.sclk        = clock_next;
        res.io_out      = level;
        res.io_drive    = drive;
        res.chip_enable = active_next;
        res.busy_res    = active_next;
        res.done_res    = done;
        res.read_data   = recv_shift_next;

        ocnt_next = ocnt_reg;
        if (step && !do_pop)
            ocnt_next = ocnt_reg + 1'b1;
        else if (do_pop && !step)
            ocnt_next = ocnt_reg - 1'b1;
    end

    assign orw_dummy = qptr_inc(owr_ptr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_shift_reg <= '0;
            recv_shift_reg <= '0;
            bit_index_reg  <= '0;
            tick_count_reg <= '0;
            read_mode_reg  <= 1'b0;
            active_reg     <= 1'b0;
            clock_reg      <= 1'b1;
            owr_ptr_reg    <= '0;
            ord_ptr_reg    <= '0;
            ocnt_reg       <= '0;
        end
        else
        begin
            if (step)
            begin
                send_shift_reg <= send_shift_next;
                recv_shift_reg <= recv_shift_next;
                bit_index_reg  <= bit_index_next;
                tick_count_reg <= tick_count_next;
                read_mode_reg  <= read_mode_next;
                active_reg     <= active_next;
                clock_reg      <= clock_next;
                owr_ptr_reg    <= orw_dummy;
            end
            if (do_pop)
                ord_ptr_reg <= qptr_inc(ord_ptr_reg);
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            oq_reg[owr_ptr_reg] <= res;
    end

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg < 5'(TotalBits))
        else $error("bit index ran past the frame");

    a_start_low: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> (!clock_reg && bit_index_reg == 5'd0 && tick_count_reg == 8'd0))
        else $error("transaction did not open with clock low at bit zero");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> (clock_reg && bit_index_reg == 5'd0))
        else $error("transaction did not close with clock idle high");

    a_idle_clock: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> clock_reg)
        else $error("serial clock low while idle");

endmodule

`default_nettype wire

// ===== rtl/three_wire_serial_master.sv =====
`default_nettype none

// Three-wire serial master (enable, clock, data), LSB first. Each beat pushed
// in is one tick of bit timing and yields exactly one result beat with the
// line levels after that tick, in order. A start request while idle sends the
// command byte, then the data byte for a write, or releases the data line and
// shifts in eight bits for a read, half_period ticks low and high per bit.
// One beat is taken per clock cycle while the result queue has room; its
// result beat enters the result queue as it leaves the item queue and can
// then be popped. Two-beat item and result queues sit either side of the
// bit engine, so a stall reaches the other side only once the queues fill.
// half_period resets to 2; write it only while no beat is in flight.
module three_wire_serial_master (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       half_period_we,
    input  wire logic [7:0] half_period_wdata,
    input  wire logic       push,
    output logic            full,
    input  wire logic       start_req,
    input  wire logic       func,
    input  wire logic [7:0] address,
    input  wire logic [7:0] write_data,
    input  wire logic       io_in,
    output logic            empty,
    input  wire logic       pop,
    output logic            sclk,
    output logic            io_out,
    output logic            io_drive,
    output logic            chip_enable,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      read_data
);
    import tws_pkg::*;

    logic [7:0]  half_period_reg;
    tws_item_t   in_item;
    tws_item_t   item;
    tws_link_t   link;
    logic        take;
    tws_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_period_reg <= HalfPeriodRst;
        else if (half_period_we)
            half_period_reg <= half_period_wdata;
    end

    assign in_item.start_req  = start_req;
    assign in_item.func       = func;
    assign in_item.address    = address;
    assign in_item.write_data = write_data;
    assign in_item.io_in      = io_in;

    tws_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .item    (item),
        .link    (link),
        .take    (take)
    );

    tws_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_period (half_period_reg),
        .item        (item),
        .link        (link),
        .take        (take),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

    assign sclk        = result.sclk;
    assign io_out      = result.io_out;
    assign io_drive    = result.io_drive;
    assign chip_enable = result.chip_enable;
    assign busy_res    = result.busy_res;
    assign done_res    = result.done_res;
    assign read_data   = result.read_data;

endmodule

`default_nettype wire
